// File: rtl/srmq_pkg.sv
`timescale 1ns / 1ps

package srmq_pkg;

  localparam int VALUE_W        = 32;
  localparam int INDEX_W        = 11;
  localparam int COUNT_W        = 11;
  localparam int ACTION_W       = 2;
  localparam int MAX_VALUES_DEF = 1024;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

// File: rtl/srmq_if.sv
`timescale 1ns / 1ps

interface srmq_in_if;
  import srmq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        range_start;
  logic [INDEX_W-1:0]        range_end;

  modport source (output valid, action, value, range_start, range_end, input ready);
  modport sink   (input valid, action, value, range_start, range_end, output ready);
endinterface

interface srmq_out_if;
  import srmq_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] best_count;
  logic               range_error;

  modport source (output valid, best_count, range_error, input ready);
  modport sink   (input valid, best_count, range_error, output ready);
endinterface

// File: rtl/srmq_ram.sv
`timescale 1ns / 1ps

module srmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sorted_range_mode_query.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    action, value, range_start, range_end
// out_chan  out  valid/ready    best_count, range_error
//
// Clear, append and ignored actions are taken in the idle state.
// A valid query holds the input off while it runs:
// one run-table read per cycle from the single run memory, then the open run,
// then the result register. A rejected query skips the scan. Reset clears counts
// and control only; the run memory needs no clearing. A stalled result keeps the
// next query's result waiting, and no appends or clears are taken while it waits.

module sorted_range_mode_query #(
  parameter int MAX_VALUES = srmq_pkg::MAX_VALUES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  srmq_in_if.sink    in_chan,
  srmq_out_if.source out_chan
);
  import srmq_pkg::*;

  localparam int AW  = $clog2(MAX_VALUES);
  localparam int CW  = $clog2(MAX_VALUES + 1);
  localparam int W   = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int RW  = AW + CW;

  state_t state_r, state_nxt;

  logic [VALUE_W-1:0] open_val_r;
  logic [AW-1:0]      open_start_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      closed_r;

  logic [CW-1:0]      idx_r;
  logic               rd_vld_r;
  logic [W-1:0]       lo_r, hi_r;
  logic [W-1:0]       ov_r;
  logic               ov_vld_r;
  logic [W-1:0]       best_r;
  logic               err_r;

  logic               out_valid_r;
  logic [COUNT_W-1:0] out_best_r;
  logic               out_err_r;

  logic               accept;
  logic               bad_range;
  logic               scan_more;
  logic               out_load;
  logic               ram_we, ram_re;
  logic [RW-1:0]      ram_wdata, ram_rdata;

  logic [W-1:0]       src_first, src_last, ov_a, ov_b, ov_nxt;

  assign accept = in_chan.valid && in_chan.ready;

  assign bad_range = (in_chan.range_start == '0) || (in_chan.range_end == '0) ||
                     (in_chan.range_start > in_chan.range_end) ||
                     (W'(in_chan.range_end) > W'(count_r));

  assign scan_more = idx_r < closed_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_chan.action == ACT_QUERY) begin
          state_nxt = bad_range ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_more && !rd_vld_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE:   in_chan.ready = 1'b1;
      ST_SCAN:   ram_re = scan_more;
      ST_RESULT: out_load = !out_valid_r || out_chan.ready;
      default:   ;
    endcase
  end

  // run closes when an append differs from the open run value
  assign ram_we    = accept && (in_chan.action == ACT_APPEND) &&
                     (count_r < CW'(MAX_VALUES)) && (count_r != '0) &&
                     (in_chan.value != open_val_r) && (closed_r < CW'(MAX_VALUES));
  assign ram_wdata = {open_start_r, count_r};

  srmq_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VALUES)
  ) u_run_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (closed_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // overlap of [first, last) with [lo, hi)
  always_comb begin
    if (rd_vld_r) begin
      src_first = W'(ram_rdata[RW-1:CW]);
      src_last  = W'(ram_rdata[CW-1:0]);
    end else begin
      src_first = W'(open_start_r);
      src_last  = W'(count_r);
    end
    ov_a   = (src_first > lo_r) ? src_first : lo_r;
    ov_b   = (src_last < hi_r) ? src_last : hi_r;
    ov_nxt = (ov_b > ov_a) ? (ov_b - ov_a) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      open_val_r   <= '0;
      open_start_r <= '0;
      count_r      <= '0;
      closed_r     <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      ov_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_re;
      ov_vld_r <= (state_r == ST_SCAN) && (rd_vld_r || !scan_more);
      if (ram_re) begin
        idx_r <= idx_r + CW'(1);
      end
      if (accept) begin
        case (in_chan.action)
          ACT_CLEAR: begin
            open_val_r   <= '0;
            open_start_r <= '0;
            count_r      <= '0;
            closed_r     <= '0;
          end
          ACT_APPEND: begin
            if (count_r < CW'(MAX_VALUES)) begin
              if (count_r == '0) begin
                open_val_r   <= in_chan.value;
                open_start_r <= '0;
              end else if (in_chan.value != open_val_r) begin
                if (closed_r < CW'(MAX_VALUES)) begin
                  closed_r <= closed_r + CW'(1);
                end
                open_val_r   <= in_chan.value;
                open_start_r <= count_r[AW-1:0];
              end
              count_r <= count_r + CW'(1);
            end
          end
          ACT_QUERY: idx_r <= '0;
          default:   ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ov_r <= ov_nxt;
    if (accept && in_chan.action == ACT_QUERY) begin
      lo_r   <= W'(in_chan.range_start) - W'(1);
      hi_r   <= W'(in_chan.range_end);
      best_r <= '0;
      err_r  <= bad_range;
    end else if (ov_vld_r && ov_r > best_r) begin
      best_r <= ov_r;
    end
    if (out_load) begin
      out_best_r <= best_r[COUNT_W-1:0];
      out_err_r  <= err_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.best_count  = out_best_r;
  assign out_chan.range_error = out_err_r;

endmodule
